/* rtl/rgb2yv12_pkg.sv */
// Shared types and constants for the RGB to YV12 pixel converter.
// No dependencies; every other file of the block imports this package.
package rgb2yv12_pkg;

  // Width of a frame size register and of the configuration write data.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // Field widths of the result.
  localparam int LUMA_IDX_W   = 24;
  localparam int CHROMA_IDX_W = 22;

  // Sizes after reset.
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // Chroma sample kinds carried by a result.
  typedef enum logic [1:0] {
    CHROMA_NONE = 2'd0,
    CHROMA_U    = 2'd1,
    CHROMA_V    = 2'd2
  } chroma_kind_e;

  // BT.601 integer coefficients.
  localparam logic [15:0] Y_R = 16'd66;
  localparam logic [15:0] Y_G = 16'd129;
  localparam logic [15:0] Y_B = 16'd25;
  localparam logic [15:0] U_R = 16'd38;
  localparam logic [15:0] U_G = 16'd74;
  localparam logic [15:0] U_B = 16'd112;
  localparam logic [15:0] V_R = 16'd112;
  localparam logic [15:0] V_G = 16'd94;
  localparam logic [15:0] V_B = 16'd18;
  localparam logic [15:0] ROUND_HALF   = 16'd128;
  localparam logic [7:0]  LUMA_OFFSET  = 8'd16;
  // Rounding plus a bias of 128 in the upper byte, so the chroma sum stays positive.
  localparam logic [15:0] CHROMA_BIAS  = 16'd32896;

  // One input pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One output result.
  typedef struct packed {
    logic [7:0]              luma;
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic [1:0]              chroma_kind;
    logic [7:0]              chroma_value;
    logic [CHROMA_IDX_W-1:0] chroma_index;
    logic                    frame_last;
  } result_t;

  // Raster position of a pixel, from the counters to the pipeline.
  typedef struct packed {
    logic [LUMA_IDX_W-1:0]   luma_index;
    logic [1:0]              chroma_kind;
    logic [CHROMA_IDX_W-1:0] chroma_index;
    logic                    frame_last;
  } pos_t;

endpackage

/* rtl/rgb2yv12_if.sv */
// Valid/ready stream interfaces for pixels in and results out.
// Depends on rgb2yv12_pkg for the payload types.
interface rgb2yv12_pix_if;
  import rgb2yv12_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgb2yv12_res_if;
  import rgb2yv12_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/rgb2yv12_raster.sv */
// Column, row and plane address counters of the raster scan.
// Depends on rgb2yv12_pkg for the position struct and chroma kinds.
module rgb2yv12_raster #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rgb2yv12_pkg::CFG_W-1:0]  frame_width_i,
  input  logic [rgb2yv12_pkg::CFG_W-1:0]  frame_height_i,
  input  logic                            advance_i,
  output rgb2yv12_pkg::pos_t              pos_o
);
  import rgb2yv12_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
  localparam int HCW = (HW > CFG_W) ? HW : CFG_W;
  localparam int PW  = RW + WW;

  logic [CW-1:0]           col_q, col_d;
  logic [RW-1:0]           row_q, row_d, row_next;
  logic [LUMA_IDX_W-1:0]   luma_pos_q, luma_pos_d;
  logic [CHROMA_IDX_W-1:0] row_base_q, row_base_d;
  logic [WW-1:0]           width_eff;
  logic [HW-1:0]           height_eff;
  logic [PW-1:0]           base_prod;
  logic                    row_end;
  logic                    last;
  chroma_kind_e            kind;

  // Clamp the configured sizes to 1..MAX.
  always_comb begin
    if (frame_width_i == '0) begin
      width_eff = WW'(1);
    end else if (WCW'(frame_width_i) > WCW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      height_eff = HW'(1);
    end else if (HCW'(frame_height_i) > HCW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height_i);
    end
  end

  // End of row and end of frame detection.
  assign row_end = (WW'(col_q) + WW'(1)) >= width_eff;
  assign last    = row_end && ((HW'(row_q) + HW'(1)) >= height_eff);

  // Chroma sites: U on even row and column, V on odd row and column.
  always_comb begin
    if (!row_q[0] && !col_q[0]) begin
      kind = CHROMA_U;
    end else if (row_q[0] && col_q[0]) begin
      kind = CHROMA_V;
    end else begin
      kind = CHROMA_NONE;
    end
  end

  // Position of the current pixel.
  always_comb begin
    pos_o.luma_index   = luma_pos_q;
    pos_o.chroma_kind  = kind;
    pos_o.chroma_index = '0;
    if (kind != CHROMA_NONE) begin
      pos_o.chroma_index = row_base_q + CHROMA_IDX_W'(col_q >> 1);
    end
    pos_o.frame_last   = last;
  end

  // Base of the next chroma row, from the row number after the increment.
  assign row_next  = row_q + RW'(1);
  assign base_prod = PW'(row_next >> 1) * PW'(width_eff);

  // Counter update on each accepted pixel.
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    luma_pos_d = luma_pos_q;
    row_base_d = row_base_q;
    if (advance_i) begin
      if (last) begin
        col_d      = '0;
        row_d      = '0;
        luma_pos_d = '0;
        row_base_d = '0;
      end else begin
        luma_pos_d = luma_pos_q + LUMA_IDX_W'(1);
        if (row_end) begin
          col_d      = '0;
          row_d      = row_next;
          row_base_d = CHROMA_IDX_W'(base_prod >> 1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      luma_pos_q <= '0;
      row_base_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      luma_pos_q <= luma_pos_d;
      row_base_q <= row_base_d;
    end
  end

  // The last pixel of a frame brings every counter back to the origin.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last |=> col_q == '0 && row_q == '0 && luma_pos_q == '0 && row_base_q == '0)
    else $error("counters did not wrap after the last pixel");

  // A row end inside the frame starts the next row at column zero.
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && row_end && !last |=> col_q == '0 && row_q == $past(row_q) + RW'(1))
    else $error("row advance failed at the end of a row");

  // Without an accepted pixel the counters hold.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(luma_pos_q) && $stable(col_q) && $stable(row_q))
    else $error("counters moved without an accepted pixel");

endmodule

/* rtl/rgb2yv12_color.sv */
// BT.601 color arithmetic: luma and the U or V sample of one pixel.
// Depends on rgb2yv12_pkg for coefficients and chroma kinds.
module rgb2yv12_color (
  input  rgb2yv12_pkg::pixel_t  pixel_i,
  input  logic [1:0]            chroma_kind_i,
  output logic [7:0]            luma_o,
  output logic [7:0]            chroma_value_o
);
  import rgb2yv12_pkg::*;

  logic [15:0] r, g, b;
  logic [15:0] luma_sum;
  logic [15:0] u_sum;
  logic [15:0] v_sum;

  assign r = 16'(pixel_i.red);
  assign g = 16'(pixel_i.green);
  assign b = 16'(pixel_i.blue);

  // Luma with rounding, then the footroom offset.
  assign luma_sum = Y_R * r + Y_G * g + Y_B * b + ROUND_HALF;
  assign luma_o   = luma_sum[15:8] + LUMA_OFFSET;

  // Chroma differences biased so the sum never goes negative.
  assign u_sum = U_B * b + CHROMA_BIAS - (U_G * g + U_R * r);
  assign v_sum = V_R * r + CHROMA_BIAS - (V_G * g + V_B * b);

  // Select the sample for this site; zero where the pixel has none.
  always_comb begin
    case (chroma_kind_i)
      CHROMA_U: chroma_value_o = u_sum[15:8];
      CHROMA_V: chroma_value_o = v_sum[15:8];
      default:  chroma_value_o = 8'd0;
    endcase
  end

endmodule

/* rtl/rgb_to_yv12_pixel_converter.sv */
// Top level of the RGB to YV12 pixel converter: frame size registers,
// input register and result register. Depends on rgb2yv12_pkg, the stream
// interfaces, rgb2yv12_raster and rgb2yv12_color.
//
// The block takes one RGB pixel per clock in raster order and gives one
// result per pixel: a registered input stage holds the pixel with its
// raster position, the color arithmetic sits between that stage and the
// result register, and the counters advance at every accepted pixel.
// Sustained rate is one pixel per cycle while the result side takes one
// result per cycle; each stage accepts when it is empty or emptying, so a
// stall on the result side holds at most two pixels. The user must write
// frame sizes only while no pixel is in flight; the block does not enforce
// this. A size of zero acts as one and one above the maximum as the maximum.
module rgb_to_yv12_pixel_converter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rgb2yv12_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rgb2yv12_pkg::CFG_W-1:0]       cfg_wdata_i,
  rgb2yv12_pix_if.sink                         pix_i,
  rgb2yv12_res_if.source                       res_o
);
  import rgb2yv12_pkg::*;

  logic [CFG_W-1:0] frame_width_q, frame_width_d;
  logic [CFG_W-1:0] frame_height_q, frame_height_d;
  logic             accept;
  logic             s1_valid_q, s1_valid_d;
  pixel_t           s1_pixel_q;
  pos_t             s1_pos_q;
  pos_t             pos;
  logic             s2_load;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;
  logic [7:0]       luma;
  logic [7:0]       chroma_value;

  // Configuration register decode.
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_d  = cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Handshake: each stage loads when it is empty or its content moves on.
  assign s2_load     = s1_valid_q && (!res_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s2_load;
  assign accept      = pix_i.valid && pix_i.ready;

  assign s1_valid_d  = accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_q);
  assign res_valid_d = s2_load ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  // Raster counters, advanced once per accepted transaction.
  rgb2yv12_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .advance_i      (accept),
    .pos_o          (pos)
  );

  // Color arithmetic on the registered pixel.
  rgb2yv12_color u_color (
    .pixel_i        (s1_pixel_q),
    .chroma_kind_i  (s1_pos_q.chroma_kind),
    .luma_o         (luma),
    .chroma_value_o (chroma_value)
  );

  always_comb begin
    res_d.luma         = luma;
    res_d.luma_index   = s1_pos_q.luma_index;
    res_d.chroma_kind  = s1_pos_q.chroma_kind;
    res_d.chroma_value = chroma_value;
    res_d.chroma_index = s1_pos_q.chroma_index;
    res_d.frame_last   = s1_pos_q.frame_last;
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q <= pix_i.data;
      s1_pos_q   <= pos;
    end
    if (s2_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // A result without chroma carries zero chroma value and index.
  a_no_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.chroma_kind == CHROMA_NONE |->
      res_q.chroma_value == 8'd0 && res_q.chroma_index == '0)
    else $error("chroma fields set on a pixel without chroma");

  // Luma always lies in the studio range.
  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.luma >= 8'd16 && res_q.luma <= 8'd235)
    else $error("luma outside 16..235");

  // A held input stage keeps its content while the result side is stalled.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_load |=> s1_valid_q && $stable(s1_pos_q))
    else $error("input stage lost a pixel during a stall");

endmodule
